// ===== rtl/ascii_number_line_entry_core_defines.svh =====
// ----------------------------------------------------------------------------
// ascii number line entry - assertion macros
// shared property wrappers for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASCII_NUMBER_LINE_ENTRY_CORE_DEFINES_SVH
`define ASCII_NUMBER_LINE_ENTRY_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ANLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ANLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/anle_pkg.sv =====
// ----------------------------------------------------------------------------
// anle_pkg
// types and constants of the ascii number line entry block
// ----------------------------------------------------------------------------
package anle_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_F   = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_F   = 8'h66;
  // low nibble of 'A'/'a' is 1, so letter value is nibble + 9
  localparam logic [3:0]        LETTER_ADJ  = 4'd9;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

  // floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for every 32-bit x
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCCCCCD;
  localparam int unsigned        DIV10_SHIFT = 35;

  typedef struct packed {
    logic                echo_valid;
    logic [CHAR_W-1:0]   echo_char;
    logic                entry_done;
    logic [VALUE_W-1:0]  entry_value;
  } anle_result_t;

endpackage

// ===== rtl/anle_ifs.sv =====
// ----------------------------------------------------------------------------
// anle channel interfaces
// valid/ready channels for characters, results and the radix register
// ----------------------------------------------------------------------------
interface anle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] typed_char;
  modport source (output valid, output typed_char, input ready);
  modport sink   (input valid, input typed_char, output ready);
endinterface

interface anle_out_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_char;
  logic        entry_done;
  logic [31:0] entry_value;
  modport source (output valid, output echo_valid, output echo_char,
                  output entry_done, output entry_value, input ready);
  modport sink   (input valid, input echo_valid, input echo_char,
                  input entry_done, input entry_value, output ready);
endinterface

interface anle_cfg_if;
  logic valid;
  logic ready;
  logic radix_hex;
  modport source (output valid, output radix_hex, input ready);
  modport sink   (input valid, input radix_hex, output ready);
endinterface

// ===== rtl/ascii_number_line_entry_core.sv =====
// ----------------------------------------------------------------------------
// ascii_number_line_entry_core
// builds an unsigned 32-bit number from typed characters with backspace
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_if     in   typed_char[7:0]
// out_if    out  echo_valid, echo_char[7:0], entry_done, entry_value[31:0]
// cfg_if    in   radix_hex
//
// one character per cycle when the output is not stalled; each character passes
// the input register, then the result register, on its way to the output
// the value/count update is combinational decode plus a 32x32 reciprocal
// multiply or shift-add, closing the loop on the state registers
// rst_n clears state, radix (decimal) and both valid flags
// a stalled output keeps its result; one more character is held at the input
// ----------------------------------------------------------------------------
module ascii_number_line_entry_core (
  input  logic        clk,
  input  logic        rst_n,
  anle_cfg_if.sink    cfg_if,
  anle_in_if.sink     in_if,
  anle_out_if.source  out_if
);
  import anle_pkg::*;

  logic              in_v_r;
  logic [CHAR_W-1:0] char_r;
  logic              radix_r;
  logic              out_v_r;
  anle_result_t      res_r;
  anle_result_t      res_nxt;
  logic              advance;

  // held character moves on when the result register is free or being drained
  assign advance      = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !in_v_r || advance;
  assign cfg_if.ready = 1'b1;

  anle_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .typed_char (char_r),
    .radix_hex  (radix_r),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      radix_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_v_r <= in_if.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        radix_r <= cfg_if.radix_hex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      char_r <= in_if.typed_char;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.echo_valid  = res_r.echo_valid;
  assign out_if.echo_char   = res_r.echo_char;
  assign out_if.entry_done  = res_r.entry_done;
  assign out_if.entry_value = res_r.entry_value;

endmodule

// ===== rtl/anle_accum.sv =====
// ----------------------------------------------------------------------------
// anle_accum
// digit decode, value/count state and result formation for one character
// ----------------------------------------------------------------------------
`include "ascii_number_line_entry_core_defines.svh"

module anle_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  typed_char,
  input  logic                        radix_hex,
  output anle_pkg::anle_result_t      result
);
  import anle_pkg::*;

  logic [VALUE_W-1:0]   value_r;
  logic [VALUE_W-1:0]   value_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [COUNT_W-1:0]   count_nxt;
  logic                 is_digit;
  logic [3:0]           digit;
  logic                 is_cr;
  logic                 is_bs;
  logic [2*VALUE_W-1:0] div10_prod;
  logic [VALUE_W-1:0]   value_div;
  logic [VALUE_W-1:0]   value_app;

  always_comb begin
    is_digit = 1'b0;
    digit    = 4'd0;
    if (typed_char >= CHAR_ZERO && typed_char <= CHAR_NINE) begin
      is_digit = 1'b1;
      digit    = typed_char[3:0];
    end else if (radix_hex &&
                 ((typed_char >= CHAR_UC_A && typed_char <= CHAR_UC_F) ||
                  (typed_char >= CHAR_LC_A && typed_char <= CHAR_LC_F))) begin
      is_digit = 1'b1;
      digit    = typed_char[3:0] + LETTER_ADJ;
    end
  end

  assign is_cr = (typed_char == CHAR_CR);
  assign is_bs = (typed_char == CHAR_BS) && (count_r != '0);

  // decimal backspace by reciprocal multiply
  assign div10_prod = {{VALUE_W{1'b0}}, value_r} * {{VALUE_W{1'b0}}, DIV10_RECIP};
  assign value_div  = radix_hex ? {4'd0, value_r[VALUE_W-1:4]}
                                : VALUE_W'(div10_prod[2*VALUE_W-1:DIV10_SHIFT]);
  // x*10 = x*8 + x*2, wrapping
  assign value_app  = radix_hex ? {value_r[VALUE_W-5:0], digit}
                                : (value_r << 3) + (value_r << 1) + VALUE_W'(digit);

  always_comb begin
    value_nxt          = value_r;
    count_nxt          = count_r;
    result.echo_valid  = 1'b0;
    result.echo_char   = '0;
    result.entry_done  = 1'b0;
    result.entry_value = '0;
    if (is_cr) begin
      result.entry_done  = 1'b1;
      result.entry_value = value_r;
      value_nxt          = '0;
      count_nxt          = '0;
    end else if (is_digit) begin
      value_nxt         = value_app;
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      result.echo_valid = 1'b1;
      result.echo_char  = typed_char;
    end else if (is_bs) begin
      value_nxt         = value_div;
      count_nxt         = count_r - 1'b1;
      result.echo_valid = 1'b1;
      result.echo_char  = typed_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      count_r <= '0;
    end else if (step) begin
      value_r <= value_nxt;
      count_r <= count_nxt;
    end
  end

  `ANLE_ASSERT_NXT(a_cr_clears, clk, rst_n, step && is_cr, value_r == '0 && count_r == '0, "carriage return did not clear state")
  `ANLE_ASSERT_NXT(a_count_sat, clk, rst_n, step && is_digit && count_r == COUNT_MAX, count_r == COUNT_MAX, "digit count wrapped past maximum")
  `ANLE_ASSERT_IMP(a_bs_needs_digit, clk, rst_n, result.echo_valid && typed_char == CHAR_BS, count_r != '0, "backspace echoed with no digits")
  `ANLE_ASSERT_IMP(a_done_no_echo, clk, rst_n, result.entry_done, !result.echo_valid, "entry end and echo together")

endmodule

// ===== tb/anle_entry_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anle_entry_checker
// watches the character, result and radix channels of the number line entry
// block, predicts the echo and entry result of every accepted character and
// compares each result request, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module anle_entry_checker
  import anle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  anle_cfg_if         cfg_ch,
  anle_in_if          in_ch,
  anle_out_if         out_ch,
  output int unsigned pending_count,
  output int unsigned fail_count
);

  localparam logic [VALUE_W-1:0] BASE_DEC     = 32'd10;
  localparam logic [VALUE_W-1:0] BASE_HEX     = 32'd16;
  localparam logic [4:0]         NO_DIGIT     = 5'h10;
  localparam logic [4:0]         FIRST_LETTER = 5'd10;
  localparam int unsigned        PRINT_CAP    = 100;

  logic               hex_mode;
  logic [VALUE_W-1:0] number_acc;
  logic [COUNT_W-1:0] digits_held;
  anle_result_t       outcome_q[$];

  initial fail_count = 0;

  // advances the entry state by one character and returns what should come out
  function automatic anle_result_t char_outcome(input logic [CHAR_W-1:0] ch);
    anle_result_t       res;
    logic [4:0]         dig;
    logic [VALUE_W-1:0] base;
    res  = '0;
    base = hex_mode ? BASE_HEX : BASE_DEC;
    dig  = NO_DIGIT;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      dig = 5'(ch - CHAR_ZERO);
    end else if (hex_mode && ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
      dig = 5'(ch - CHAR_UC_A) + FIRST_LETTER;
    end else if (hex_mode && ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
      dig = 5'(ch - CHAR_LC_A) + FIRST_LETTER;
    end
    if (ch == CHAR_CR) begin
      res.entry_done  = 1'b1;
      res.entry_value = number_acc;
      number_acc      = '0;
      digits_held     = '0;
    end else if (dig != NO_DIGIT) begin
      number_acc = number_acc * base + VALUE_W'(dig);
      // count sticks at its top, value keeps wrapping
      if (digits_held != COUNT_MAX) begin
        digits_held = digits_held + 1'b1;
      end
      res.echo_valid = 1'b1;
      res.echo_char  = ch;
    end else if (ch == CHAR_BS && digits_held != '0) begin
      number_acc     = number_acc / base;
      digits_held    = digits_held - 1'b1;
      res.echo_valid = 1'b1;
      res.echo_char  = ch;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    anle_result_t want;
    if (!rst_n) begin
      hex_mode    = 1'b0;
      number_acc  = '0;
      digits_held = '0;
      outcome_q.delete();
      pending_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request pending", out_ch.entry_value, '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_ch.echo_valid !== want.echo_valid) begin
            report_mismatch("echo_valid", out_ch.echo_valid, want.echo_valid);
          end
          if (out_ch.echo_char !== want.echo_char) begin
            report_mismatch("echo_char", out_ch.echo_char, want.echo_char);
          end
          if (out_ch.entry_done !== want.entry_done) begin
            report_mismatch("entry_done", out_ch.entry_done, want.entry_done);
          end
          if (out_ch.entry_value !== want.entry_value) begin
            report_mismatch("entry_value", out_ch.entry_value, want.entry_value);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        hex_mode = cfg_ch.radix_hex;
      end
      if (in_ch.valid && in_ch.ready) begin
        outcome_q.push_back(char_outcome(in_ch.typed_char));
      end
      pending_count <= outcome_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression for ascii_number_line_entry_core: directed characters, then
// random entries in both radices under three idling mixes; results are
// checked by anle_entry_checker
// ----------------------------------------------------------------------------
module tb;
  import anle_pkg::*;

  localparam int unsigned HANG_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_CHARS  = 170;
  localparam logic        RADIX_DEC    = 1'b0;
  localparam logic        RADIX_HEX    = 1'b1;
  localparam int unsigned DEC_DIGITS   = 10;

  localparam int unsigned DEC_LEN = 9;
  localparam logic [CHAR_W-1:0] DEC_SCRIPT [DEC_LEN] = '{
    CHAR_BS, 8'h00, 8'hFF, 8'h3A, CHAR_LC_A, CHAR_NINE, CHAR_ZERO, CHAR_BS, CHAR_CR
  };
  // nine hex digits so the value wraps, then letters just outside the ranges
  localparam int unsigned HEX_LEN = 16;
  localparam logic [CHAR_W-1:0] HEX_SCRIPT [HEX_LEN] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, CHAR_UC_F, CHAR_LC_F, CHAR_UC_A, CHAR_LC_A,
    8'h47, 8'h67, 8'h40, 8'h60, 8'h2F, CHAR_BS, CHAR_CR
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        radix_now      = RADIX_DEC;
  int unsigned send_idle_pct  = 20;
  int unsigned recv_stall_pct = 83;
  int unsigned quiet_cycles   = 0;
  int unsigned chars_sent     = 0;
  int unsigned pending_count;
  int unsigned fail_count;

  anle_in_if  in_if ();
  anle_out_if out_if ();
  anle_cfg_if cfg_if ();

  ascii_number_line_entry_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  anle_entry_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ch        (cfg_if),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("ascii_number_line_entry_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays up after a request so back-to-back characters need no gap
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.typed_char <= ch;
    do @(posedge clk); while (!in_if.ready);
    chars_sent++;
  endtask

  // only written once every character in flight has produced its result
  task automatic write_radix(input logic hex);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    cfg_if.valid     <= 1'b1;
    cfg_if.radix_hex <= hex;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    radix_now = hex;
  endtask

  function automatic logic [CHAR_W-1:0] typed_digit();
    logic [3:0] d;
    d = radix_now ? 4'($urandom_range(15)) : 4'($urandom_range(DEC_DIGITS - 1));
    if (d < 4'(DEC_DIGITS)) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return ($urandom_range(1) ? CHAR_UC_A : CHAR_LC_A) + CHAR_W'(d - 4'(DEC_DIGITS));
  endfunction

  // mostly digit runs ended by carriage return, with backspaces and stray bytes
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned       goal;
    int unsigned       len;
    int unsigned       roll;
    logic [CHAR_W-1:0] ch;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal = chars_sent + PHASE_CHARS;
    while (chars_sent < goal) begin
      // a radix write may land in the middle of an unfinished entry
      if ($urandom_range(3) == 0) begin
        write_radix(1'($urandom_range(1)));
      end
      len = $urandom_range(12, 1);
      repeat (len) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          ch = typed_digit();
        end else if (roll < 85) begin
          ch = CHAR_BS;
        end else begin
          ch = CHAR_W'($urandom_range(255));
        end
        send_char(ch);
      end
      if ($urandom_range(9) != 0) begin
        send_char(CHAR_CR);
      end
    end
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.typed_char <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.radix_hex <= RADIX_DEC;
    rst_n            <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_radix(RADIX_DEC);
    for (int i = 0; i < DEC_LEN; i++) begin
      send_char(DEC_SCRIPT[i]);
    end
    write_radix(RADIX_HEX);
    for (int i = 0; i < HEX_LEN; i++) begin
      send_char(HEX_SCRIPT[i]);
    end
    // switch to decimal with hex digits already held
    send_char(CHAR_LC_F);
    send_char(8'h31);
    write_radix(RADIX_DEC);
    send_char(8'h33);
    send_char(CHAR_CR);

    run_phase(20, 83);
    run_phase(83, 20);
    run_phase(0, 0);

    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ascii_number_line_entry_core regression: pass");
    end else begin
      $display("ascii_number_line_entry_core regression: fail");
    end
    $finish;
  end

endmodule
